### hw/rtl/kwm_pkg.sv
`timescale 1ns / 1ps
package kwm_pkg;
    localparam int LANES = 8;
    localparam int LANE_W = 3;
    localparam int CNT_W = 4;
    localparam int VAL_W = 32;
    localparam logic [CNT_W-1:0] LANES_RESET = 4'd8;
    localparam logic KIND_VALUE = 1'b0;
    localparam logic KIND_EXHAUST = 1'b1;

    typedef struct packed {
        logic                 kind;
        logic [LANE_W-1:0]    lane;
        logic [VAL_W-1:0]     value;
    } t_in_word;

    typedef struct packed {
        logic [VAL_W-1:0]     value_res;
        logic [LANE_W-1:0]    lane_res;
        logic                 done_res;
    } t_out_word;

    // Maps a float bit pattern to an unsigned key in numeric order, zeros equal.
    function automatic logic [VAL_W-1:0] order_key(input logic [VAL_W-1:0] bits);
        logic [VAL_W-1:0] k;
        if (bits[VAL_W-2:0] == '0) begin
            k = {1'b1, {(VAL_W-1){1'b0}}};
        end else if (bits[VAL_W-1]) begin
            k = ~bits;
        end else begin
            k = bits | {1'b1, {(VAL_W-1){1'b0}}};
        end
        return k;
    endfunction
endpackage

### hw/rtl/kwm_if.sv
`timescale 1ns / 1ps
interface kwm_in_if;
    import kwm_pkg::*;
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface kwm_out_if;
    import kwm_pkg::*;
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface kwm_cfg_if;
    import kwm_pkg::*;
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/kwm_select.sv
`timescale 1ns / 1ps
// Picks the smallest present head among live lanes; lowest lane wins ties.
module kwm_select (
    input  logic [kwm_pkg::LANES-1:0][kwm_pkg::VAL_W-1:0] i_head,
    input  logic [kwm_pkg::LANES-1:0]                     i_present,
    output logic [kwm_pkg::LANE_W-1:0]                    o_best
);
    import kwm_pkg::*;
    logic [VAL_W-1:0]  t_key  [LANES];
    logic              t_have [LANES];
    logic [LANE_W-1:0] t_lane [LANES];

    // Pairwise compare tree over the lanes, log2(LANES) compares deep. The
    // right side of a pair wins only when strictly smaller, so ties keep the
    // lower lane.
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            t_key[i]  = order_key(i_head[i]);
            t_have[i] = i_present[i];
            t_lane[i] = LANE_W'(i);
        end
        for (int step = 1; step < LANES; step = step * 2) begin
            for (int i = 0; i + step < LANES; i = i + 2 * step) begin
                if (t_have[i + step] && (!t_have[i] || t_key[i + step] < t_key[i])) begin
                    t_have[i] = 1'b1;
                    t_key[i]  = t_key[i + step];
                    t_lane[i] = t_lane[i + step];
                end
            end
        end
        o_best = t_lane[0];
    end
endmodule

### hw/rtl/k_way_merge_engine_core.sv
`timescale 1ns / 1ps
// Merges up to eight ascending float streams. Each input word either loads
// a lane head, marks the lane exhausted or is ignored. It is absorbed when
// accepted, and at most one output word follows in the next cycle. One input
// word is taken every cycle; the only stall is a full output register that
// is not being drained. After every lane is exhausted the feeder keeps
// sending words (such as repeated exhaust marks) until the done word appears.
module k_way_merge_engine_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    kwm_in_if.sink        in_ch,
    kwm_out_if.source     out_ch,
    kwm_cfg_if.sink       cfg_ch
);
    import kwm_pkg::*;

    logic [LANES-1:0][VAL_W-1:0] r_head;
    logic [LANES-1:0][VAL_W-1:0] n_head;
    logic [LANES-1:0]            r_present, n_present;
    logic [LANES-1:0]            held;
    logic [LANES-1:0]            r_exh, n_exh;
    logic                        r_finished, n_finished;
    logic [CNT_W-1:0]            r_lanes;
    logic                        r_out_valid;
    t_out_word                   r_out;
    logic [LANES-1:0]            live;
    logic [LANE_W-1:0]           best;
    logic                        accept, all_ready, any_head, emit, load;
    t_out_word                   n_out;

    assign in_ch.ready  = !r_out_valid || out_ch.ready;
    assign accept       = in_ch.valid && in_ch.ready;
    assign cfg_ch.ready = 1'b1;
    assign out_ch.valid = r_out_valid;
    assign out_ch.data  = r_out;

    // Lanes at or above the count are treated as exhausted.
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            live[i] = (CNT_W'(i) < r_lanes);
        end
    end

    // Absorb the input word into the head state.
    always_comb begin
        held  = r_present;
        n_exh = r_exh;
        load  = 1'b0;
        if (live[in_ch.data.lane]) begin
            if (in_ch.data.kind == KIND_EXHAUST) begin
                n_exh[in_ch.data.lane] = 1'b1;
            end else if (!r_present[in_ch.data.lane] && !r_exh[in_ch.data.lane]) begin
                held[in_ch.data.lane] = 1'b1;
                load                  = 1'b1;
            end
        end
    end

    // Head values as seen after the word is absorbed.
    always_comb begin
        n_head = r_head;
        if (load) begin
            n_head[in_ch.data.lane] = in_ch.data.value;
        end
    end

    kwm_select u_select (
        .i_head    (n_head),
        .i_present (held & live),
        .o_best    (best)
    );

    // Decide whether this word causes an output.
    always_comb begin
        any_head   = |(held & live);
        all_ready  = &(held | n_exh | ~live);
        emit       = !r_finished && all_ready;
        n_finished = r_finished;
        n_present  = held;
        n_out      = '0;
        if (any_head) begin
            n_out.value_res = n_head[best];
            n_out.lane_res  = best;
            if (emit) begin
                n_present[best] = 1'b0;
            end
        end else begin
            n_out.done_res = 1'b1;
            n_finished     = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present   <= '0;
            r_exh       <= '0;
            r_finished  <= 1'b0;
            r_lanes     <= LANES_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                r_lanes <= cfg_ch.data;
            end
            if (accept && emit) begin
                r_out_valid <= 1'b1;
            end else if (out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
            if (accept && !r_finished) begin
                r_exh     <= n_exh;
                r_present <= n_present;
                if (emit) begin
                    r_finished <= n_finished;
                end
            end
        end
    end

    // Head values carry no reset.
    always_ff @(posedge i_clk) begin
        if (accept && load) begin
            r_head[in_ch.data.lane] <= in_ch.data.value;
        end
        if (accept && emit) begin
            r_out <= n_out;
        end
    end
endmodule

### hw/rtl/kwm_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the merge engine.
module kwm_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input kwm_pkg::t_out_word         out_data
);
    import kwm_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output word changed while stalled");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_data.done_res |-> out_data.value_res == '0 && out_data.lane_res == '0)
        else $error("done word carries data");
    a_nosrc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(in_valid && in_ready) && !$past(out_valid) |-> !out_valid)
        else $error("output without an input");
endmodule

bind k_way_merge_engine_core kwm_checker u_kwm_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
);

### dv/tb_k_way_merge_engine_core.sv
`timescale 1ns / 1ps
module tb_k_way_merge_engine_core;
    import kwm_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic i_clk;
    logic i_rst_n;

    kwm_in_if  in_ch ();
    kwm_out_if out_ch ();
    kwm_cfg_if cfg_ch ();

    k_way_merge_engine_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source),
        .cfg_ch  (cfg_ch.sink)
    );

    // Shadow of the merge state, updated as each word is accepted.
    logic [VAL_W-1:0] mirror_head [LANES];
    bit               mirror_full [LANES];
    bit               mirror_dry  [LANES];
    bit               mirror_done;
    logic [CNT_W-1:0] mirror_lanes;

    t_out_word merged_q[$];
    int        fail_count;
    int        cycle_count;
    int        sent_words;
    int        merged_values;
    int        done_words;
    int        burst_left;

    // Clock and cycle limit.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Unsigned rank of a float pattern in numeric order, both zeros equal.
    function automatic logic [VAL_W-1:0] float_rank(input logic [VAL_W-1:0] b);
        if (b[VAL_W-2:0] == '0) return 32'h8000_0000;
        if (b[VAL_W-1]) return ~b;
        return b | 32'h8000_0000;
    endfunction

    function automatic int live_lanes();
        return (mirror_lanes > LANES) ? LANES : int'(mirror_lanes);
    endfunction

    // Absorbs one accepted word and queues the merged word it produces, if any.
    task automatic absorb_word(input t_in_word w);
        int n;
        bit all_ready;
        bit any_head;
        int best;
        t_out_word r;
        n = live_lanes();
        all_ready = 1'b1;
        any_head = 1'b0;
        best = -1;
        if (mirror_done) return;
        if (w.lane < n) begin
            if (w.kind == KIND_EXHAUST) begin
                mirror_dry[w.lane] = 1'b1;
            end else if (!mirror_full[w.lane] && !mirror_dry[w.lane]) begin
                mirror_head[w.lane] = w.value;
                mirror_full[w.lane] = 1'b1;
            end
        end
        for (int i = 0; i < n; i++) begin
            if (mirror_full[i]) begin
                any_head = 1'b1;
                if (best < 0 || float_rank(mirror_head[i]) < float_rank(mirror_head[best]))
                    best = i;
            end else if (!mirror_dry[i]) begin
                all_ready = 1'b0;
            end
        end
        if (any_head && all_ready) begin
            r.value_res = mirror_head[best];
            r.lane_res = LANE_W'(best);
            r.done_res = 1'b0;
            mirror_full[best] = 1'b0;
            merged_q.insert(merged_q.size(), r);
        end else if (!any_head && all_ready) begin
            r = '0;
            r.done_res = 1'b1;
            mirror_done = 1'b1;
            merged_q.insert(merged_q.size(), r);
        end
    endtask

    // Sends one word, with bursts of random length separated by random gaps.
    task automatic send_word(input logic kind, input int lane, input logic [VAL_W-1:0] value);
        t_in_word w;
        int gap;
        w.kind = kind;
        w.lane = LANE_W'(lane);
        w.value = value;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 5);
            @(negedge i_clk);
            if (gap != 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end else begin
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= w;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        absorb_word(w);
        sent_words++;
        burst_left--;
    endtask

    // Waits until every expected word has come and the block has settled.
    task automatic wait_idle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (merged_q.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic set_lane_count(input logic [CNT_W-1:0] count);
        wait_idle();
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= count;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        mirror_lanes = count;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        logic [VAL_W-1:0] odd [8] = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000,
                                      32'hFF80_0000, 32'h7F7F_FFFF, 32'hFF7F_FFFF,
                                      32'h0000_0001, 32'h7FC0_0000};
        if ($urandom_range(0, 9) == 0) return odd[$urandom_range(0, 7)];
        return $urandom();
    endfunction

    // Lowest live lane that still waits for a head, or -1.
    function automatic int hungry_lane();
        for (int i = 0; i < live_lanes(); i++)
            if (!mirror_full[i] && !mirror_dry[i]) return i;
        return -1;
    endfunction

    // Mostly refills lanes that wait for a head; the rest is noise.
    task automatic send_random_word();
        int r;
        int lane;
        r = $urandom_range(0, 99);
        lane = hungry_lane();
        if (r < 75 && lane >= 0) begin
            if ($urandom_range(0, 1) == 1) begin
                // Pick a random waiting lane rather than the lowest one.
                for (int t = 0; t < 8; t++) begin
                    int c;
                    c = $urandom_range(0, live_lanes() - 1);
                    if (!mirror_full[c] && !mirror_dry[c]) begin
                        lane = c;
                        break;
                    end
                end
            end
            send_word(KIND_VALUE, lane, pick_value());
        end else if (r < 90 || live_lanes() == LANES) begin
            send_word(KIND_VALUE, $urandom_range(0, LANES - 1), pick_value());
        end else begin
            send_word(KIND_EXHAUST, $urandom_range(live_lanes(), LANES - 1), pick_value());
        end
    endtask

    // Receiver stall pattern: ready follows one of four randomly chosen modes.
    initial begin
        int mode;
        int left;
        out_ch.ready = 1'b0;
        mode = 0;
        left = 0;
        forever begin
            @(negedge i_clk);
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(10, 60);
            end
            left--;
            case (mode)
                0: begin
                    out_ch.ready <= 1'b1;
                end
                1: begin
                    out_ch.ready <= ($urandom_range(0, 1) == 1);
                end
                2: begin
                    out_ch.ready <= ($urandom_range(0, 4) == 0);
                end
                default: begin
                    out_ch.ready <= ((cycle_count % 4) != 0);
                end
            endcase
        end
    end

    // Compares each merged word with the oldest expectation.
    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (merged_q.size() == 0) begin
                $error("unexpected word: value %h lane %0d done %0b",
                       out_ch.data.value_res, out_ch.data.lane_res, out_ch.data.done_res);
                fail_count++;
            end else begin
                exp_w = merged_q.pop_front();
                if (out_ch.data.value_res !== exp_w.value_res) begin
                    $error("value_res: expected %h, got %h", exp_w.value_res,
                           out_ch.data.value_res);
                    fail_count++;
                end
                if (out_ch.data.lane_res !== exp_w.lane_res) begin
                    $error("lane_res: expected %0d, got %0d", exp_w.lane_res,
                           out_ch.data.lane_res);
                    fail_count++;
                end
                if (out_ch.data.done_res !== exp_w.done_res) begin
                    $error("done_res: expected %0b, got %0b", exp_w.done_res,
                           out_ch.data.done_res);
                    fail_count++;
                end
                if (exp_w.done_res) done_words++;
                else merged_values++;
            end
        end
    end

    // Float extremes, ties of signed zeros, NaN patterns and pushes to busy lanes,
    // with an oversized lane count that must act as all lanes.
    task automatic test_directed_extremes();
        logic [VAL_W-1:0] seed_vals [8] = '{32'h8000_0000, 32'h0000_0000, 32'h7F80_0000,
                                            32'hFF80_0000, 32'h7F7F_FFFF, 32'hFF7F_FFFF,
                                            32'h0000_0001, 32'h8000_0001};
        set_lane_count(4'd15);
        for (int i = 0; i < LANES; i++) send_word(KIND_VALUE, i, seed_vals[i]);
        send_word(KIND_VALUE, 0, 32'h1234_5678);
        send_word(KIND_VALUE, hungry_lane(), 32'h7FC0_0000);
        send_word(KIND_VALUE, hungry_lane(), 32'hFFC0_0000);
        send_word(KIND_VALUE, hungry_lane(), 32'hFFFF_FFFF);
        for (int i = 0; i < 10; i++) send_word(KIND_VALUE, hungry_lane(), 32'h0000_0000);
    endtask

    // Random merging under several lane counts, the narrowest and widest included.
    task automatic test_random_merge();
        logic [CNT_W-1:0] counts [5] = '{4'd8, 4'd1, 4'd3, 4'd2, 4'd6};
        foreach (counts[k]) begin
            set_lane_count(counts[k]);
            repeat (80) send_random_word();
        end
    endtask

    // Exhausts lanes while they still hold heads, then a zero lane count ends
    // the merge; words after the done word must be ignored.
    task automatic test_exhaust_and_finish();
        set_lane_count(4'd8);
        for (int i = 0; i < LANES; i++)
            if (!mirror_full[i] && !mirror_dry[i]) send_word(KIND_VALUE, i, pick_value());
        for (int i = 0; i < 4; i++) begin
            send_word(KIND_EXHAUST, i, 32'hFFFF_FFFF);
            send_word(KIND_EXHAUST, i, 32'h0);
        end
        repeat (12) send_random_word();
        set_lane_count(4'd0);
        send_word(KIND_EXHAUST, 7, 32'h0);
        for (int i = 0; i < 6; i++) send_word(i[0], i, pick_value());
    endtask

    initial begin
        fail_count = 0;
        cycle_count = 0;
        sent_words = 0;
        merged_values = 0;
        done_words = 0;
        burst_left = 0;
        for (int i = 0; i < LANES; i++) begin
            mirror_head[i] = '0;
            mirror_full[i] = 1'b0;
            mirror_dry[i] = 1'b0;
        end
        mirror_done = 1'b0;
        mirror_lanes = LANES_RESET;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_extremes();
        test_random_merge();
        test_exhaust_and_finish();

        wait_idle();
        repeat (5) @(posedge i_clk);
        $display("Sent %0d words under lane counts 15, 8, 1, 3, 2, 6 and 0.", sent_words);
        $display("Checked %0d merged values and %0d done word(s).", merged_values, done_words);
        if (fail_count == 0 && merged_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

### filelist.f
hw/rtl/kwm_pkg.sv
hw/rtl/kwm_if.sv
hw/rtl/kwm_select.sv
hw/rtl/k_way_merge_engine_core.sv
hw/rtl/kwm_checker.sv
dv/tb_k_way_merge_engine_core.sv
